@@ design/krt_pkg.sv @@
// ----------------------------------------------------------------------------
// krt_pkg: shared types for the keyed record table
// Record layout, operation and status codes, and the per-cell command word.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int KEY_W         = 16;
  localparam int TAG_W         = 32;
  localparam int MARK_W        = 16;
  localparam int REC_W         = KEY_W + TAG_W + MARK_W;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FOUND     = 3'd3,
    ST_DELETED   = 3'd4,
    ST_LISTED    = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  // key sits in the lowest bits, matching the stream data layout
  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [TAG_W-1:0]  tag;
    logic [KEY_W-1:0]  key;
  } rec_t;

  // rotate: every cell takes its upper neighbor (ring)
  // compact: cells at or above the selected index take their upper neighbor
  // load: the selected cell takes the incoming record
  typedef struct packed {
    logic rotate;
    logic compact;
    logic load;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ design/krt_cell.sv @@
// ----------------------------------------------------------------------------
// krt_cell: one record slot of the table
// Holds a record and takes a new one from the input or from its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  wire logic                clk,
  input  wire krt_pkg::cell_cmd_t  cmd,
  input  wire logic [IDX_W-1:0]    sel_idx,
  input  wire krt_pkg::rec_t       load_rec,
  input  wire krt_pkg::rec_t       next_rec,
  output krt_pkg::rec_t            rec_q
);

  krt_pkg::rec_t rec_r;
  krt_pkg::rec_t rec_nxt;
  logic          hit_sel;
  logic          above_sel;

  assign hit_sel   = (sel_idx == IDX_W'(CELL_IDX));
  assign above_sel = (sel_idx <= IDX_W'(CELL_IDX));

  always_comb begin
    rec_nxt = rec_r;
    if (cmd.load && hit_sel) begin
      rec_nxt = load_rec;
    end else if (cmd.rotate || (cmd.compact && above_sel)) begin
      rec_nxt = next_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_q = rec_r;

endmodule

`default_nettype wire

@@ design/krt_ctrl.sv @@
// ----------------------------------------------------------------------------
// krt_ctrl: sequencer of the keyed record table
// Decodes items, walks the cell ring, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_ctrl #(
  parameter int TABLE_DEPTH = krt_pkg::DEPTH_DEFAULT,
  parameter int IDX_W       = 6,
  parameter int CNT_W       = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire krt_pkg::op_t       in_op,
  input  wire logic [krt_pkg::KEY_W-1:0] in_key,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output krt_pkg::status_t        out_status,
  output krt_pkg::rec_t           out_rec,
  output logic                    out_last,
  input  wire krt_pkg::rec_t      head_rec,
  output krt_pkg::cell_cmd_t      cmd,
  output logic [IDX_W-1:0]        sel_idx
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_EMIT} state_t;

  state_t                      state_r, state_nxt;
  krt_pkg::op_t                op_r, op_nxt;
  logic [krt_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [IDX_W-1:0]            step_r, step_nxt;
  logic                        hit_r, hit_nxt;
  logic [IDX_W-1:0]            hit_idx_r, hit_idx_nxt;
  krt_pkg::status_t            res_status_r, res_status_nxt;
  krt_pkg::rec_t               res_rec_r, res_rec_nxt;
  logic                        out_valid_r, out_valid_nxt;
  krt_pkg::status_t            out_status_r, out_status_nxt;
  krt_pkg::rec_t               out_rec_r, out_rec_nxt;
  logic                        out_last_r, out_last_nxt;

  logic in_fire;
  logic out_free;
  logic table_full;
  logic in_range;
  logic emit_now;
  logic advance;
  logic last_step;
  logic match;
  logic hit_now;
  logic last_entry;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign table_full = (count_r == CNT_W'(TABLE_DEPTH));
  assign in_range   = (CNT_W'(step_r) < count_r);
  assign emit_now   = (op_r == krt_pkg::OP_LIST) && in_range;
  assign advance    = !emit_now || out_free;
  assign last_step  = (step_r == IDX_W'(TABLE_DEPTH - 1));
  assign match      = (op_r != krt_pkg::OP_LIST) && in_range && !hit_r &&
                      (head_rec.key == key_r);
  assign hit_now    = hit_r || match;
  assign last_entry = ((CNT_W'(step_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_last_nxt   = out_last_r;
    cmd            = '0;
    sel_idx        = hit_idx_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_op;
          key_nxt     = in_key;
          hit_nxt     = 1'b0;
          step_nxt    = '0;
          res_rec_nxt = '0;
          case (in_op)
            krt_pkg::OP_ADD: begin
              state_nxt = S_EMIT;
              if (table_full) begin
                res_status_nxt = krt_pkg::ST_FULL;
              end else begin
                cmd.load       = 1'b1;
                sel_idx        = count_r[IDX_W-1:0];
                count_nxt      = count_r + CNT_W'(1);
                res_status_nxt = krt_pkg::ST_ADDED;
              end
            end
            krt_pkg::OP_LIST: begin
              if (count_r == '0) begin
                res_status_nxt = krt_pkg::ST_EMPTY;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_SCAN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // hold the ring while a listed entry waits for the output slot
        if (advance) begin
          cmd.rotate = 1'b1;
          step_nxt   = last_step ? '0 : step_r + IDX_W'(1);
          if (match) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = step_r;
            if (op_r == krt_pkg::OP_SEARCH) begin
              res_rec_nxt = head_rec;
            end
          end
          if (emit_now) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = krt_pkg::ST_LISTED;
            out_rec_nxt    = head_rec;
            out_last_nxt   = last_entry;
          end
          if (last_step) begin
            case (op_r)
              krt_pkg::OP_SEARCH: begin
                res_status_nxt = hit_now ? krt_pkg::ST_FOUND : krt_pkg::ST_NOT_FOUND;
                state_nxt      = S_EMIT;
              end
              krt_pkg::OP_DELETE: begin
                if (hit_now) begin
                  state_nxt = S_SHIFT;
                end else begin
                  res_status_nxt = krt_pkg::ST_NOT_FOUND;
                  state_nxt      = S_EMIT;
                end
              end
              default: begin
                state_nxt = S_IDLE;
              end
            endcase
          end
        end
      end

      S_SHIFT: begin
        // close the gap left by the deleted record
        cmd.compact    = 1'b1;
        count_nxt      = count_r - CNT_W'(1);
        res_status_nxt = krt_pkg::ST_DELETED;
        state_nxt      = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rec_nxt    = res_rec_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      step_r       <= step_nxt;
      hit_r        <= hit_nxt;
      out_valid_r  <= out_valid_nxt;
      op_r         <= op_nxt;
      key_r        <= key_nxt;
      hit_idx_r    <= hit_idx_nxt;
      res_status_r <= res_status_nxt;
      res_rec_r    <= res_rec_nxt;
      out_status_r <= out_status_nxt;
      out_rec_r    <= out_rec_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_rec    = out_rec_r;
  assign out_last   = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ((count_r == $past(count_r) + CNT_W'(1)) ||
       (count_r + CNT_W'(1) == $past(count_r))))
    else $error("entry count moved by more than one");

  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (step_r == '0))
    else $error("ring not back in place when idle");

  a_shift_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> hit_r)
    else $error("compaction without a matching record");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_op == krt_pkg::OP_ADD) && table_full) |=>
      (count_r == $past(count_r)))
    else $error("add into a full table changed the count");

endmodule

`default_nettype wire

@@ design/compacting_keyed_record_table_top.sv @@
// ----------------------------------------------------------------------------
// compacting_keyed_record_table_top: keyed record table in insertion order
// Add, search, delete with compaction, and list, over a ring of record cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_t*: in_tuser carries the operation (add, search,
//   delete, list), in_tdata the key, name tag and mark. Results leave on out_t*:
//   out_tuser carries the status, out_tdata the record, out_tlast marks the
//   final result of an item. A list gives one result per stored record, or a
//   single empty result on an empty table. One item is in work at a time. Add
//   and an empty list go straight to the result register. Search and delete
//   rotate the whole ring of TABLE_DEPTH cells once, one cell per cycle, and
//   then place the result (a delete that hits first runs the compaction
//   shift). A list emits entry i on rotation step i, and the next item is
//   taken once the full rotation is done. Otherwise the next item is taken as
//   soon as the last result is in the output register.
//   Reset: the entry count clears; record cells are not cleared and are read
//   only after they are written.
//   Stall: a full output register stops the ring during a list; single results
//   wait in the sequencer, and no new item is taken until they are placed.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_keyed_record_table_top #(
  parameter int TABLE_DEPTH = krt_pkg::DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // record_key[15:0], name_tag[47:16], mark_value[63:48]
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // out_key[15:0], out_name_tag[47:16], out_mark[63:48]
  output logic [2:0]       out_tuser,  // status[2:0]
  output logic             out_tlast
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  krt_pkg::rec_t      in_rec;
  krt_pkg::rec_t      cell_q [TABLE_DEPTH];
  krt_pkg::cell_cmd_t cmd;
  logic [IDX_W-1:0]   sel_idx;
  krt_pkg::status_t   out_status;
  krt_pkg::rec_t      out_rec;

  assign in_rec = krt_pkg::rec_t'(in_tdata);

  krt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (krt_pkg::op_t'(in_tuser)),
    .in_key     (in_rec.key),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_rec    (out_rec),
    .out_last   (out_tlast),
    .head_rec   (cell_q[0]),
    .cmd        (cmd),
    .sel_idx    (sel_idx)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    krt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .sel_idx  (sel_idx),
      .load_rec (in_rec),
      .next_rec (cell_q[(i + 1) % TABLE_DEPTH]),
      .rec_q    (cell_q[i])
    );
  end

  assign out_tdata = 64'(out_rec);
  assign out_tuser = 3'(out_status);

endmodule

`default_nettype wire

@@ verif/tb_compacting_keyed_record_table_top.sv @@
// ----------------------------------------------------------------------------
// tb_compacting_keyed_record_table_top: keyed record table stream testbench
// Drives add, search, delete and list items in bursts against a shadow copy of
// the table. Every result is checked field by field, in order, against the
// replies that the shadow table predicts. The receiver stalls on its own
// changing pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_compacting_keyed_record_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = TABLE_DEPTH + 16;

  typedef struct {
    krt_pkg::status_t status;
    logic [15:0]      key;
    logic [31:0]      tag;
    logic [15:0]      mark;
    logic             last;
  } table_reply_t;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_BURSTY
  } rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // shadow table
  logic [15:0] shadow_key  [TABLE_DEPTH];
  logic [31:0] shadow_tag  [TABLE_DEPTH];
  logic [15:0] shadow_mark [TABLE_DEPTH];
  int          entry_cnt = 0;

  table_reply_t replies_due[$];

  int n_errors   = 0;
  int n_checked  = 0;
  int n_full     = 0;
  int n_missed   = 0;
  int n_items    = 0;
  int op_count[4];
  int burst_left = 0;

  compacting_keyed_record_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_reply(krt_pkg::status_t st, logic [15:0] key,
                                     logic [31:0] tag, logic [15:0] mark, logic last);
    table_reply_t r;
    r.status = st;
    r.key    = key;
    r.tag    = tag;
    r.mark   = mark;
    r.last   = last;
    replies_due.push_back(r);
  endfunction

  function automatic int find_first(logic [15:0] key);
    for (int i = 0; i < entry_cnt; i++) begin
      if (shadow_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one accepted item to the shadow table and queue its replies.
  function automatic void table_apply(krt_pkg::op_t op, logic [15:0] key,
                                      logic [31:0] tag, logic [15:0] mark);
    int hit;
    hit = -1;
    case (op)
      krt_pkg::OP_ADD: begin
        if (entry_cnt >= TABLE_DEPTH) begin
          n_full++;
          push_reply(krt_pkg::ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          shadow_key[entry_cnt]  = key;
          shadow_tag[entry_cnt]  = tag;
          shadow_mark[entry_cnt] = mark;
          entry_cnt++;
          push_reply(krt_pkg::ST_ADDED, '0, '0, '0, 1'b1);
        end
      end
      krt_pkg::OP_SEARCH: begin
        hit = find_first(key);
        if (hit < 0) begin
          n_missed++;
          push_reply(krt_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
        end else begin
          push_reply(krt_pkg::ST_FOUND, shadow_key[hit], shadow_tag[hit],
                     shadow_mark[hit], 1'b1);
        end
      end
      krt_pkg::OP_DELETE: begin
        hit = find_first(key);
        if (hit < 0) begin
          n_missed++;
          push_reply(krt_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
        end else begin
          // close the gap, keeping insertion order
          for (int i = hit; i + 1 < entry_cnt; i++) begin
            shadow_key[i]  = shadow_key[i+1];
            shadow_tag[i]  = shadow_tag[i+1];
            shadow_mark[i] = shadow_mark[i+1];
          end
          entry_cnt--;
          push_reply(krt_pkg::ST_DELETED, '0, '0, '0, 1'b1);
        end
      end
      default: begin
        if (entry_cnt == 0) begin
          push_reply(krt_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < entry_cnt; i++) begin
            push_reply(krt_pkg::ST_LISTED, shadow_key[i], shadow_tag[i], shadow_mark[i],
                       (i + 1 == entry_cnt));
          end
        end
      end
    endcase
  endfunction

  // Send one item; the sender runs in bursts with random gaps between them.
  task automatic push_item(krt_pkg::op_t op, logic [15:0] key, logic [31:0] tag,
                           logic [15:0] mark);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {mark, tag, key};
    do @(posedge clk); while (!in_tready);
    table_apply(op, key, tag, mark);
    op_count[op]++;
    n_items++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Hold off the sender until every queued reply has arrived.
  task automatic wait_for_drain();
    hold_input();
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  // Mostly a small pool of keys so that hits and duplicates are common.
  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 3) == 0) return 16'($urandom());
    return 16'(16'h0100 + $urandom_range(0, 7));
  endfunction

  // Prefer keys that are stored, to get hits anywhere in the table.
  function automatic logic [15:0] pick_stored_key();
    if (entry_cnt > 0 && $urandom_range(0, 9) < 7)
      return shadow_key[$urandom_range(0, entry_cnt - 1)];
    return pick_key();
  endfunction

  task automatic test_directed();
    push_item(krt_pkg::OP_LIST,   16'h0000, '0, '0);
    push_item(krt_pkg::OP_SEARCH, 16'h1234, '0, '0);
    push_item(krt_pkg::OP_DELETE, 16'h1234, '0, '0);
    push_item(krt_pkg::OP_ADD,    16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(krt_pkg::OP_ADD,    16'h0000, 32'h0000_0000, 16'h0000);
    push_item(krt_pkg::OP_ADD,    16'h00A5, 32'hA5A5_A5A5, 16'd10000);
    push_item(krt_pkg::OP_ADD,    16'h00A5, 32'h5A5A_5A5A, 16'd1);
    push_item(krt_pkg::OP_SEARCH, 16'h00A5, $urandom(), 16'($urandom()));
    push_item(krt_pkg::OP_SEARCH, 16'hFFFF, '0, '0);
    push_item(krt_pkg::OP_SEARCH, 16'h0000, '0, '0);
    push_item(krt_pkg::OP_SEARCH, 16'h7777, '0, '0);
    push_item(krt_pkg::OP_LIST,   16'h0000, '0, '0);
    push_item(krt_pkg::OP_DELETE, 16'h00A5, '0, '0);
    push_item(krt_pkg::OP_SEARCH, 16'h00A5, '0, '0);
    push_item(krt_pkg::OP_DELETE, 16'hFFFF, '0, '0);
    push_item(krt_pkg::OP_DELETE, 16'h7777, '0, '0);
    push_item(krt_pkg::OP_LIST,   16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(krt_pkg::OP_DELETE, 16'h00A5, '0, '0);
    push_item(krt_pkg::OP_DELETE, 16'h0000, '0, '0);
    push_item(krt_pkg::OP_LIST,   16'h0000, '0, '0);
  endtask

  task automatic test_table_full();
    while (entry_cnt < TABLE_DEPTH)
      push_item(krt_pkg::OP_ADD, pick_key(), $urandom(), 16'($urandom()));
    push_item(krt_pkg::OP_ADD, pick_key(), $urandom(), 16'($urandom()));
    push_item(krt_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_item(krt_pkg::OP_SEARCH, shadow_key[TABLE_DEPTH-1], '0, '0);
    push_item(krt_pkg::OP_LIST, '0, '0, '0);
    push_item(krt_pkg::OP_DELETE, shadow_key[0], '0, '0);
    push_item(krt_pkg::OP_ADD, 16'($urandom()), $urandom(), 16'($urandom()));
    push_item(krt_pkg::OP_ADD, 16'($urandom()), $urandom(), 16'($urandom()));
    push_item(krt_pkg::OP_DELETE, shadow_key[TABLE_DEPTH-1], '0, '0);
  endtask

  // Weighted mix of operations; weights are out of 100, search takes the rest.
  task automatic test_random_mix(int n, int add_w, int del_w, int list_w);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < add_w)
        push_item(krt_pkg::OP_ADD, pick_key(), $urandom(), 16'($urandom()));
      else if (roll < add_w + del_w)
        push_item(krt_pkg::OP_DELETE, pick_stored_key(), $urandom(), 16'($urandom()));
      else if (roll < add_w + del_w + list_w)
        push_item(krt_pkg::OP_LIST, 16'($urandom()), $urandom(), 16'($urandom()));
      else
        push_item(krt_pkg::OP_SEARCH, pick_stored_key(), $urandom(), 16'($urandom()));
    end
  endtask

  // Receiver: ready pattern switches between open, random, periodic and bursty.
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold      = 0;
  int       rx_tick      = 0;

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(0, 9) < 7);
      RX_PERIODIC: out_tready <= (rx_tick % 3 == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_hold = $urandom_range(5, 20);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    endcase
  end

  // Compare each accepted result with the oldest queued reply.
  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (replies_due.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: status %0d key %h tag %h mark %h last %b",
                 $realtime, out_tuser, out_tdata[15:0], out_tdata[47:16],
                 out_tdata[63:48], out_tlast);
      end else begin
        want = replies_due.pop_front();
        if (want.status != out_tuser || want.key != out_tdata[15:0] ||
            want.tag != out_tdata[47:16] || want.mark != out_tdata[63:48] ||
            want.last != out_tlast) begin
          n_errors++;
          $display("%0t: mismatch: expected status %0d key %h tag %h mark %h last %b, %s",
                   $realtime, want.status, want.key, want.tag, want.mark, want.last,
                   $sformatf("actual status %0d key %h tag %h mark %h last %b",
                             out_tuser, out_tdata[15:0], out_tdata[47:16],
                             out_tdata[63:48], out_tlast));
        end
      end
    end
  end

  // End the run when nothing moves on either side for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d replies outstanding",
               $realtime, IDLE_LIMIT, replies_due.size());
      $display("tb_compacting_keyed_record_table_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (op_count[i]) op_count[i] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_table_full();
    wait_for_drain();
    test_random_mix(60, 20, 55, 5);
    wait_for_drain();
    test_random_mix(60, 40, 25, 10);
    test_random_mix(60, 70, 10, 5);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d items (add %0d, search %0d, delete %0d, list %0d), %0d results checked",
             n_items, op_count[krt_pkg::OP_ADD], op_count[krt_pkg::OP_SEARCH],
             op_count[krt_pkg::OP_DELETE], op_count[krt_pkg::OP_LIST], n_checked);
    $display("run: %0d adds refused on a full table, %0d searches or deletes missed",
             n_full, n_missed);
    if (n_errors == 0 && replies_due.size() == 0) begin
      $display("tb_compacting_keyed_record_table_top: PASS");
    end else begin
      $display("%0d errors, %0d replies outstanding", n_errors, replies_due.size());
      $display("tb_compacting_keyed_record_table_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
